// File: src/segment_segment_distance_squared_defines.svh
// assertion macros used by the checker file
`ifndef SEGMENT_SEGMENT_DISTANCE_SQUARED_DEFINES_SVH
`define SEGMENT_SEGMENT_DISTANCE_SQUARED_DEFINES_SVH

// condition holds, then consequence in the next cycle
`define SSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssd assertion failed");

// condition holds, then consequence in the same cycle
`define SSD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssd assertion failed");

`endif

// File: src/ssd_pkg.sv
// shared constants for the segment distance pipeline
`default_nettype none
package ssd_pkg;
	localparam int COORD_BITS_DEF      = 24;
	localparam int COORD_FRAC_BITS_DEF = 12;
	localparam int RATIO_FRAC_BITS_DEF = 24;
	localparam int THRESH_BITS         = 32;
	localparam int THRESH_FRAC_BITS    = 24;
	localparam int DIST_FRAC_BITS      = 24;
	localparam int OUT_BITS            = 52;
	localparam int OUT_TDATA_BITS      = 56;
	localparam int NUM_COORDS          = 8;
	localparam int MUL_LAT             = 3;
	localparam logic [THRESH_BITS-1:0] THRESH_RESET = 32'd1;
endpackage
`default_nettype wire

// File: src/ssd_mul.sv
// pipelined signed multiplier built from four half-width partial products
`default_nettype none
module ssd_mul
	import ssd_pkg::*;
#(
	parameter int AW = 51,
	parameter int BW = 51
) (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [AW-1:0]    a,
	input  wire logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0]      p
);
	localparam int PW = AW + BW;
	localparam int AL = (AW + 1) / 2;
	localparam int AH = AW - AL;
	localparam int BL = (BW + 1) / 2;
	localparam int BH = BW - BL;

	logic [AW-1:0] au, a_mag;
	logic [BW-1:0] bu, b_mag;
	logic [AW-1:0] a_mag_s1;
	logic [BW-1:0] b_mag_s1;
	logic          neg_s1;
	logic [AL+BL-1:0] ll_s2;
	logic [AL+BH-1:0] lh_s2;
	logic [AH+BL-1:0] hl_s2;
	logic [AH+BH-1:0] hh_s2;
	logic             neg_s2;
	logic [PW-1:0]    full;

	assign au    = a;
	assign bu    = b;
	assign a_mag = au[AW-1] ? (~au + 1'b1) : au;
	assign b_mag = bu[BW-1] ? (~bu + 1'b1) : bu;

	assign full = (PW'(hh_s2) << (AL + BL)) + (PW'(hl_s2) << AL)
		+ (PW'(lh_s2) << BL) + PW'(ll_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			a_mag_s1 <= a_mag;
			b_mag_s1 <= b_mag;
			neg_s1   <= au[AW-1] ^ bu[BW-1];
			ll_s2    <= a_mag_s1[AL-1:0] * b_mag_s1[BL-1:0];
			lh_s2    <= a_mag_s1[AL-1:0] * b_mag_s1[BW-1:BL];
			hl_s2    <= a_mag_s1[AW-1:AL] * b_mag_s1[BL-1:0];
			hh_s2    <= a_mag_s1[AW-1:AL] * b_mag_s1[BW-1:BL];
			neg_s2   <= neg_s1;
			p        <= neg_s2 ? $signed(~full + 1'b1) : $signed(full);
		end
	end
endmodule
`default_nettype wire

// File: src/ssd_div.sv
// restoring divider, one quotient bit per pipeline stage
`default_nettype none
module ssd_div
	import ssd_pkg::*;
#(
	parameter int NW = 103,
	parameter int QB = 25
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [NW-1:0] den,
	output logic [QB-1:0]      q
);
	logic [NW:0]   rem_s [1:QB];
	logic [NW-1:0] dn_s  [1:QB];
	logic [QB-1:0] q_s   [1:QB];

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [NW:0]   rem_in;
		logic [NW-1:0] dn_in;
		logic [QB-1:0] q_in;
		logic          ge;
		logic [NW:0]   diff;

		if (k == 0) begin : g_first
			assign rem_in = {1'b0, num};
			assign dn_in  = den;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign dn_in  = dn_s[k];
			assign q_in   = q_s[k];
		end

		assign ge   = rem_in >= {1'b0, dn_in};
		assign diff = ge ? (rem_in - {1'b0, dn_in}) : rem_in;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= {diff[NW-1:0], 1'b0};
				dn_s[k+1]  <= dn_in;
				q_s[k+1]   <= {q_in[QB-2:0], ge};
			end
		end
	end

	assign q = q_s[QB];
endmodule
`default_nettype wire

// File: src/segment_segment_distance_squared.sv
// top level: squared distance between two 2d segments, fully pipelined
// throughput: one word per cycle while the output is not stalled, the ratio dividers resolve one bit per stage
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset clears the stage valid bits and loads the threshold with THRESH_RESET, a raw value of one lsb
`default_nettype none
module segment_segment_distance_squared
	import ssd_pkg::*;
#(
	parameter int COORD_BITS      = COORD_BITS_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
	parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// first_start_x, first_start_y, first_end_x, first_end_y,
	// second_start_x, second_start_y, second_end_x, second_end_y
	input  wire logic [NUM_COORDS*COORD_BITS-1:0] s_axis_tdata,
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// distance_squared, zero padded
	output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
	input  wire logic                   cfg_wr_en,
	input  wire logic [THRESH_BITS-1:0] cfg_wr_data
);
	localparam int F      = COORD_FRAC_BITS;
	localparam int R      = RATIO_FRAC_BITS;
	localparam int DIF_W  = COORD_BITS + 1;
	localparam int PR_W   = 2 * DIF_W;
	localparam int DOT_W  = PR_W + 1;
	localparam int MUL_W  = 2 * DOT_W;
	localparam int NUM_RW = MUL_W + 1;
	localparam int UP_W   = DOT_W + 1 + 2 * F;
	localparam int ONE_W  = 4 * F + 2;
	localparam int NW0    = (NUM_RW > UP_W) ? NUM_RW : UP_W;
	localparam int NW     = (NW0 > ONE_W) ? NW0 : ONE_W;
	localparam int CMP_A  = NW + THRESH_FRAC_BITS;
	localparam int CMP_B  = THRESH_BITS + 4 * F;
	localparam int CMP_W  = ((CMP_A > CMP_B) ? CMP_A : CMP_B) + 1;
	localparam int QB     = R + 1;
	localparam int SP_W   = QB + 1 + DIF_W;
	localparam int DX_A   = DIF_W + R;
	localparam int DX_W   = ((DX_A > SP_W) ? DX_A : SP_W) + 2;
	localparam int SQ_W   = 2 * DX_W;
	localparam int SUM_W  = SQ_W + 1;
	localparam int SCL_W  = SUM_W + DIST_FRAC_BITS;
	localparam int LAT    = QB + 18;

	typedef struct packed {
		logic signed [DIF_W-1:0] ux;
		logic signed [DIF_W-1:0] uy;
		logic signed [DIF_W-1:0] vx;
		logic signed [DIF_W-1:0] vy;
		logic signed [DIF_W-1:0] wx;
		logic signed [DIF_W-1:0] wy;
	} geo_t;

	typedef struct packed {
		logic signed [DOT_W-1:0] a;
		logic signed [DOT_W-1:0] b;
		logic signed [DOT_W-1:0] c;
		logic signed [DOT_W-1:0] d;
		logic signed [DOT_W-1:0] e;
	} dots_t;

	function automatic logic signed [NW-1:0] up(input logic signed [DOT_W:0] v);
		logic signed [NW-1:0] r;
		r = NW'(v);
		return r <<< (2 * F);
	endfunction

	logic [THRESH_BITS-1:0] thr_q;

	function automatic logic below_thr(input logic signed [NW-1:0] x);
		logic [NW-1:0]    xu;
		logic [NW-1:0]    mag;
		logic [CMP_W-1:0] lhs;
		logic [CMP_W-1:0] rhs;
		xu  = x;
		mag = xu[NW-1] ? (~xu + 1'b1) : xu;
		lhs = CMP_W'(mag) << THRESH_FRAC_BITS;
		rhs = CMP_W'(thr_q) << (4 * F);
		return lhs < rhs;
	endfunction

	logic           en;
	logic [LAT:1]   vld_s;

	logic signed [COORD_BITS-1:0] pt [NUM_COORDS];
	geo_t  geo_s1, geo_s2, geo_s3;
	logic signed [PR_W-1:0] uux_s2, uuy_s2, uvx_s2, uvy_s2, vvx_s2, vvy_s2;
	logic signed [PR_W-1:0] uwx_s2, uwy_s2, vwx_s2, vwy_s2;
	dots_t dots_s3;
	dots_t dm_s [MUL_LAT];
	geo_t  gm_s [MUL_LAT];
	logic signed [MUL_W-1:0] ac_s6, bb_s6, be_s6, cd_s6, ae_s6, bd_s6;

	logic signed [NW-1:0] dd_s7, sn_s7, tn_s7;
	dots_t dots_s7;
	geo_t  geo_s7;

	logic signed [NW-1:0] sn_a, sd_a, tn_a, td_a;
	logic signed [NW-1:0] sn_s8, sd_s8, tn_s8, td_s8;
	dots_t dots_s8;
	geo_t  geo_s8;

	logic signed [NW-1:0] tn_b;
	logic signed [DOT_W:0] m_b;
	logic                  clamp_b;
	logic signed [NW-1:0]  sn_s9, sd_s9, tn_s9, td_s9;
	logic signed [DOT_W:0] m_s9;
	logic                  clamp_s9;
	logic signed [DOT_W-1:0] a_s9;
	geo_t                  geo_s9;

	logic signed [NW-1:0] sn_c, sd_c;
	logic signed [NW-1:0] sn_s10, sd_s10, tn_s10, td_s10;
	geo_t                 geo_s10;

	logic                 s_zero, t_zero;
	logic [NW-1:0]        snum_s11, sden_s11, tnum_s11, tden_s11;
	geo_t                 geo_s11;
	geo_t                 gd_s [QB];
	logic [QB-1:0]        sc, tc;

	logic signed [SP_W-1:0] scux_s12, scuy_s12, tcvx_s12, tcvy_s12;
	logic signed [DIF_W-1:0] wx_s12, wy_s12;
	logic signed [DX_W-1:0] dx_s13, dy_s13;
	logic signed [SQ_W-1:0] dx2_s16, dy2_s16;
	logic [SUM_W-1:0]       dist_s17;
	logic [SCL_W-1:0]       scaled;
	logic [OUT_BITS-1:0]    res_s18;

	// whole pipeline moves unless a finished word is held back
	assign en            = !vld_s[LAT] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s[LAT];
	assign m_axis_tdata  = {(OUT_TDATA_BITS-OUT_BITS)'(0), res_s18};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], s_axis_tvalid};
		end
	end

	for (genvar k = 0; k < NUM_COORDS; k++) begin : g_unpack
		assign pt[k] = s_axis_tdata[k*COORD_BITS +: COORD_BITS];
	end

	// differences, dot products
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1.ux <= DIF_W'(pt[2]) - DIF_W'(pt[0]);
			geo_s1.uy <= DIF_W'(pt[3]) - DIF_W'(pt[1]);
			geo_s1.vx <= DIF_W'(pt[6]) - DIF_W'(pt[4]);
			geo_s1.vy <= DIF_W'(pt[7]) - DIF_W'(pt[5]);
			geo_s1.wx <= DIF_W'(pt[0]) - DIF_W'(pt[4]);
			geo_s1.wy <= DIF_W'(pt[1]) - DIF_W'(pt[5]);

			uux_s2 <= geo_s1.ux * geo_s1.ux;
			uuy_s2 <= geo_s1.uy * geo_s1.uy;
			uvx_s2 <= geo_s1.ux * geo_s1.vx;
			uvy_s2 <= geo_s1.uy * geo_s1.vy;
			vvx_s2 <= geo_s1.vx * geo_s1.vx;
			vvy_s2 <= geo_s1.vy * geo_s1.vy;
			uwx_s2 <= geo_s1.ux * geo_s1.wx;
			uwy_s2 <= geo_s1.uy * geo_s1.wy;
			vwx_s2 <= geo_s1.vx * geo_s1.wx;
			vwy_s2 <= geo_s1.vy * geo_s1.wy;
			geo_s2 <= geo_s1;

			dots_s3.a <= DOT_W'(uux_s2) + DOT_W'(uuy_s2);
			dots_s3.b <= DOT_W'(uvx_s2) + DOT_W'(uvy_s2);
			dots_s3.c <= DOT_W'(vvx_s2) + DOT_W'(vvy_s2);
			dots_s3.d <= DOT_W'(uwx_s2) + DOT_W'(uwy_s2);
			dots_s3.e <= DOT_W'(vwx_s2) + DOT_W'(vwy_s2);
			geo_s3    <= geo_s2;
		end
	end

	ssd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_ac (
		.clk(clk), .en(en), .a(dots_s3.a), .b(dots_s3.c), .p(ac_s6));
	ssd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_bb (
		.clk(clk), .en(en), .a(dots_s3.b), .b(dots_s3.b), .p(bb_s6));
	ssd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_be (
		.clk(clk), .en(en), .a(dots_s3.b), .b(dots_s3.e), .p(be_s6));
	ssd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_cd (
		.clk(clk), .en(en), .a(dots_s3.c), .b(dots_s3.d), .p(cd_s6));
	ssd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_ae (
		.clk(clk), .en(en), .a(dots_s3.a), .b(dots_s3.e), .p(ae_s6));
	ssd_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_bd (
		.clk(clk), .en(en), .a(dots_s3.b), .b(dots_s3.d), .p(bd_s6));

	always_ff @(posedge clk) begin
		if (en) begin
			dm_s[0] <= dots_s3;
			gm_s[0] <= geo_s3;
			for (int k = 1; k < MUL_LAT; k++) begin
				dm_s[k] <= dm_s[k-1];
				gm_s[k] <= gm_s[k-1];
			end
		end
	end

	// determinant and raw numerators
	always_ff @(posedge clk) begin
		if (en) begin
			dd_s7   <= NW'(ac_s6) - NW'(bb_s6);
			sn_s7   <= NW'(be_s6) - NW'(cd_s6);
			tn_s7   <= NW'(ae_s6) - NW'(bd_s6);
			dots_s7 <= dm_s[MUL_LAT-1];
			geo_s7  <= gm_s[MUL_LAT-1];
		end
	end

	// near-parallel fallback and clamp of the first parameter
	always_comb begin
		sn_a = '0;
		sd_a = NW'(1) << (4 * F);
		tn_a = up((DOT_W+1)'(dots_s7.e));
		td_a = up((DOT_W+1)'(dots_s7.c));
		if (!below_thr(dd_s7)) begin
			sd_a = dd_s7;
			if (sn_s7[NW-1]) begin
				sn_a = '0;
			end else if (sn_s7 > dd_s7) begin
				sn_a = dd_s7;
				tn_a = up((DOT_W+1)'(dots_s7.e) + (DOT_W+1)'(dots_s7.b));
			end else begin
				sn_a = sn_s7;
				tn_a = tn_s7;
				td_a = dd_s7;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s8   <= sn_a;
			sd_s8   <= sd_a;
			tn_s8   <= tn_a;
			td_s8   <= td_a;
			dots_s8 <= dots_s7;
			geo_s8  <= geo_s7;
		end
	end

	// clamp of the second parameter
	always_comb begin
		tn_b    = tn_s8;
		m_b     = '0;
		clamp_b = 1'b1;
		if (tn_s8[NW-1]) begin
			tn_b = '0;
			m_b  = -(DOT_W+1)'(dots_s8.d);
		end else if (tn_s8 > td_s8) begin
			tn_b = td_s8;
			m_b  = (DOT_W+1)'(dots_s8.b) - (DOT_W+1)'(dots_s8.d);
		end else begin
			clamp_b = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s9    <= sn_s8;
			sd_s9    <= sd_s8;
			tn_s9    <= tn_b;
			td_s9    <= td_s8;
			m_s9     <= m_b;
			clamp_s9 <= clamp_b;
			a_s9     <= dots_s8.a;
			geo_s9   <= geo_s8;
		end
	end

	// first parameter recomputed after the second was clamped
	always_comb begin
		sn_c = sn_s9;
		sd_c = sd_s9;
		if (clamp_s9) begin
			if (m_s9[DOT_W]) begin
				sn_c = '0;
			end else if (m_s9 > (DOT_W+1)'(a_s9)) begin
				sn_c = sd_s9;
			end else begin
				sn_c = up(m_s9);
				sd_c = up((DOT_W+1)'(a_s9));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s10  <= sn_c;
			sd_s10  <= sd_c;
			tn_s10  <= tn_s9;
			td_s10  <= td_s9;
			geo_s10 <= geo_s9;
		end
	end

	// small, negative or degenerate ratios go in as zero over one
	assign s_zero = below_thr(sn_s10) || (sd_s10 == '0) || sd_s10[NW-1] || sn_s10[NW-1];
	assign t_zero = below_thr(tn_s10) || (td_s10 == '0) || td_s10[NW-1] || tn_s10[NW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			snum_s11 <= s_zero ? '0 : sn_s10;
			sden_s11 <= s_zero ? NW'(1) : sd_s10;
			tnum_s11 <= t_zero ? '0 : tn_s10;
			tden_s11 <= t_zero ? NW'(1) : td_s10;
			geo_s11  <= geo_s10;
		end
	end

	ssd_div #(.NW(NW), .QB(QB)) u_div_s (
		.clk(clk), .en(en), .num(snum_s11), .den(sden_s11), .q(sc));
	ssd_div #(.NW(NW), .QB(QB)) u_div_t (
		.clk(clk), .en(en), .num(tnum_s11), .den(tden_s11), .q(tc));

	always_ff @(posedge clk) begin
		if (en) begin
			gd_s[0] <= geo_s11;
			for (int k = 1; k < QB; k++) begin
				gd_s[k] <= gd_s[k-1];
			end
		end
	end

	// closest-point difference vector
	always_ff @(posedge clk) begin
		if (en) begin
			scux_s12 <= $signed({1'b0, sc}) * gd_s[QB-1].ux;
			scuy_s12 <= $signed({1'b0, sc}) * gd_s[QB-1].uy;
			tcvx_s12 <= $signed({1'b0, tc}) * gd_s[QB-1].vx;
			tcvy_s12 <= $signed({1'b0, tc}) * gd_s[QB-1].vy;
			wx_s12   <= gd_s[QB-1].wx;
			wy_s12   <= gd_s[QB-1].wy;

			dx_s13 <= (DX_W'(wx_s12) <<< R) + DX_W'(scux_s12) - DX_W'(tcvx_s12);
			dy_s13 <= (DX_W'(wy_s12) <<< R) + DX_W'(scuy_s12) - DX_W'(tcvy_s12);
		end
	end

	ssd_mul #(.AW(DX_W), .BW(DX_W)) u_mul_dx (
		.clk(clk), .en(en), .a(dx_s13), .b(dx_s13), .p(dx2_s16));
	ssd_mul #(.AW(DX_W), .BW(DX_W)) u_mul_dy (
		.clk(clk), .en(en), .a(dy_s13), .b(dy_s13), .p(dy2_s16));

	assign scaled = {dist_s17, DIST_FRAC_BITS'(0)} >> (2 * F + 2 * R);

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s17 <= SUM_W'($unsigned(dx2_s16)) + SUM_W'($unsigned(dy2_s16));
			res_s18  <= (|scaled[SCL_W-1:OUT_BITS]) ? '1 : scaled[OUT_BITS-1:0];
		end
	end
endmodule
`default_nettype wire

// File: src/ssd_checker.sv
// port-level checks for the segment distance block, bound to the top level
`default_nettype none
`include "segment_segment_distance_squared_defines.svh"
module ssd_checker
	import ssd_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_axis_tvalid,
	input wire logic                      s_axis_tready,
	input wire logic                      m_axis_tvalid,
	input wire logic                      m_axis_tready,
	input wire logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);
	// a held word stays and keeps its value
	`SSD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`SSD_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	// padding above the distance is always zero
	`SSD_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_BITS-1:OUT_BITS] == '0)
	// input is only held off while the output is stalled
	`SSD_ASSERT_NOW(a_no_stall, m_axis_tready, s_axis_tready)
	// an offered word with the sink ready is always taken
	`SSD_ASSERT_NOW(a_take_in, s_axis_tvalid && m_axis_tready, s_axis_tready)
endmodule

bind segment_segment_distance_squared ssd_checker u_ssd_checker (.*);
`default_nettype wire
